/* src/bit_field_packer_unpacker_unit_assert.svh */
// Assertion macros for the bit-field packer and unpacker.
// Included by bit_field_packer_unpacker_unit, which checks its own logic; needs no package.
// With SYNTH defined every macro expands to nothing.
`ifndef BIT_FIELD_PACKER_UNPACKER_UNIT_ASSERT_SVH
`define BIT_FIELD_PACKER_UNPACKER_UNIT_ASSERT_SVH

`ifndef SYNTH

// The consequent must hold in the same cycle as the antecedent.
`define BFPU_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BFPU_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

// The condition must never be seen at a clock edge.
`define BFPU_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
		else $error(msg);

`else

`define BFPU_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg)
`define BFPU_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`define BFPU_ASSERT_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

/* src/bfpu_pkg.sv */
// Shared constants, operation codes and the access plan type of the bit-field
// packer and unpacker. No dependencies.
`default_nettype none

package bfpu_pkg;

	localparam int STORE_BYTES_DEF    = 256;
	localparam int MAX_FIELD_BITS_DEF = 32;

	localparam int VALUE_W = 32;
	localparam int WIDTH_W = 6;
	localparam int POS_W   = 12;
	localparam int BYTE_W  = 8;

	localparam logic [1:0] OP_WRITE  = 2'd0;
	localparam logic [1:0] OP_READ   = 2'd1;
	localparam logic [1:0] OP_REWIND = 2'd2;

	localparam logic STATUS_DONE    = 1'b0;
	localparam logic STATUS_REFUSED = 1'b1;

	// Decisions taken for one item when it is accepted.
	typedef struct packed {
		logic       refused;
		logic       access;
		logic       is_write;
		logic [2:0] tail_shift;
	} plan_t;

endpackage

`default_nettype wire

/* src/bfpu_plan.sv */
// Access planner: range checks, cursor updates and byte alignment of a field.
// Depends on bfpu_pkg.
`default_nettype none

module bfpu_plan import bfpu_pkg::*; #(
	parameter int STORE_BYTES    = STORE_BYTES_DEF,
	parameter int MAX_FIELD_BITS = MAX_FIELD_BITS_DEF,
	localparam int CAP_BITS = STORE_BYTES * 8,
	localparam int CW       = $clog2(CAP_BITS + 1),
	localparam int AW       = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1,
	localparam int NBMAX    = (MAX_FIELD_BITS + 6) / 8 + 1,
	localparam int NBW      = $clog2(NBMAX + 1),
	localparam int WB       = 8 * NBMAX
) (
	input  wire logic [1:0]         operation,
	input  wire logic [VALUE_W-1:0] field_value,
	input  wire logic [WIDTH_W-1:0] field_width,
	input  wire logic [CW-1:0]      cursor,
	input  wire logic [CW-1:0]      written,
	output plan_t                   plan,
	output logic [AW-1:0]           first_byte,
	output logic [NBW-1:0]          nbytes,
	output logic [WB-1:0]           wbuf,
	output logic [CW-1:0]           next_cursor,
	output logic [CW-1:0]           next_written
);

	localparam int SW = ((CW > WIDTH_W) ? CW : WIDTH_W) + 1;
	localparam int VX = (MAX_FIELD_BITS > VALUE_W) ? MAX_FIELD_BITS : VALUE_W;

	logic                      is_wr, is_rd, too_wide, fit_cur, fit_wr;
	logic [SW-1:0]             cur_x, wr_x, w_x, cur_end, wr_end;
	logic [WIDTH_W:0]          span;
	logic [CW-1:0]             cur_byte;
	logic [VX-1:0]             value_x;
	logic [MAX_FIELD_BITS-1:0] field_mask, field_bits;

	assign is_wr = (operation == OP_WRITE);
	assign is_rd = (operation == OP_READ);

	assign cur_x   = SW'(cursor);
	assign wr_x    = SW'(written);
	assign w_x     = SW'(field_width);
	assign cur_end = cur_x + w_x;
	assign wr_end  = wr_x + w_x;

	assign too_wide = w_x > SW'(MAX_FIELD_BITS);
	assign fit_cur  = cur_end <= SW'(CAP_BITS);
	assign fit_wr   = wr_end <= SW'(CAP_BITS);

	assign plan.refused  = (is_wr || is_rd) && (too_wide || !fit_cur || (is_wr && !fit_wr));
	assign plan.access   = (is_wr || is_rd) && !plan.refused && (field_width != '0);
	assign plan.is_write = is_wr;

	// Bit offset of the last bit of the field, counted from the first byte.
	assign span = (WIDTH_W + 1)'(cursor[2:0]) + (WIDTH_W + 1)'(field_width)
		- (WIDTH_W + 1)'(1);
	assign plan.tail_shift = ~span[2:0];
	assign nbytes          = NBW'(span[WIDTH_W:3] + 4'd1);

	assign cur_byte   = cursor >> 3;
	assign first_byte = cur_byte[AW-1:0];

	// The field, right-aligned to the end of its last byte.
	assign value_x    = VX'(field_value);
	assign field_mask = ~({MAX_FIELD_BITS{1'b1}} << field_width);
	assign field_bits = value_x[MAX_FIELD_BITS-1:0] & field_mask;
	assign wbuf       = WB'(field_bits) << plan.tail_shift;

	always_comb begin
		next_cursor  = cursor;
		next_written = written;
		if (operation == OP_REWIND) begin
			next_cursor = '0;
		end else if (plan.access) begin
			next_cursor = CW'(cur_end);
			if (is_wr) begin
				next_written = CW'(wr_end);
			end
		end
	end

endmodule

`default_nettype wire

/* src/bit_field_packer_unpacker_unit.sv */
// Bit-field packer and unpacker: writes fields of 1 to MAX_FIELD_BITS bits
// most significant bit first into a byte store at a bit cursor, and reads them
// back the same way. Operations are write (OR the field into the store and
// advance the cursor and the written total), read (extract the field at the
// cursor and advance the cursor) and rewind (cursor back to zero). An access
// that would take the cursor, or for a write the written total, past the end
// of the store, or one wider than MAX_FIELD_BITS, is refused with status 1
// and changes nothing. Every input transfer yields exactly one result
// transfer. After reset the store is cleared by a pass over all STORE_BYTES
// bytes, one byte a cycle, during which no input is taken. Items are handled
// one at a time: an access keeps the block busy while each byte it spans goes
// through the single read port of the store and is written back in the cycle
// after it is read; rewinds, zero-width, refused and unused operations skip
// the store. A finished result waits in an output register, so the next item is
// taken while it is still unclaimed. A 32-bit field spans at most five bytes.
`default_nettype none

`include "bit_field_packer_unpacker_unit_assert.svh"

module bit_field_packer_unpacker_unit import bfpu_pkg::*; #(
	parameter int STORE_BYTES    = STORE_BYTES_DEF,
	parameter int MAX_FIELD_BITS = MAX_FIELD_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               item_valid,
	output logic                    item_stall,
	input  wire logic [1:0]         operation,
	input  wire logic [VALUE_W-1:0] field_value,
	input  wire logic [WIDTH_W-1:0] field_width,
	output logic                    result_valid,
	input  wire logic               result_stall,
	output logic [VALUE_W-1:0]      read_data,
	output logic                    status,
	output logic [POS_W-1:0]        cursor_position,
	output logic [POS_W-1:0]        written_total
);

	localparam int CAP_BITS = STORE_BYTES * 8;
	localparam int CW       = $clog2(CAP_BITS + 1);
	localparam int AW       = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
	localparam int NBMAX    = (MAX_FIELD_BITS + 6) / 8 + 1;
	localparam int NBW      = $clog2(NBMAX + 1);
	localparam int IXW      = (NBMAX > 1) ? $clog2(NBMAX) : 1;
	localparam int WB       = 8 * NBMAX;
	localparam int DW       = (WB > VALUE_W) ? WB : VALUE_W;
	localparam int XW       = (CW > POS_W) ? CW : POS_W;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ACCESS,
		ST_FINISH
	} state_t;

	state_t state_q;

	// Architectural state held in flip-flops.
	logic [CW-1:0]  cursor_q, written_q;
	logic [AW-1:0]  clr_addr_q;

	// Item in progress.
	logic             status_q, is_write_q, v_s1;
	logic [2:0]       tail_q;
	logic [WIDTH_W-1:0] width_q;
	logic [NBW-1:0]   left_q;
	logic [AW-1:0]    rd_addr_q, addr_s1;
	logic [IXW-1:0]   idx_s1;
	logic [BYTE_W-1:0] wbuf_q [NBMAX];
	logic [WB-1:0]    win_q;
	logic [BYTE_W-1:0] rdata_s1;

	// Result register.
	logic               res_valid_q, res_status_q;
	logic [VALUE_W-1:0] res_data_q;
	logic [POS_W-1:0]   res_cursor_q, res_written_q;

	// The byte store.
	logic [BYTE_W-1:0] store_mem [STORE_BYTES];
	logic              mem_we;
	logic [AW-1:0]     mem_wa;
	logic [BYTE_W-1:0] mem_wd;

	plan_t          plan;
	logic [AW-1:0]  plan_first;
	logic [NBW-1:0] plan_nbytes;
	logic [WB-1:0]  plan_wbuf;
	logic [CW-1:0]  plan_cursor, plan_written;

	logic           in_xfer, issue, res_load;
	logic [WB-1:0]  read_mask, read_bits;
	logic [DW-1:0]  read_x;
	logic [XW-1:0]  cursor_x, written_x;

	bfpu_plan #(
		.STORE_BYTES   (STORE_BYTES),
		.MAX_FIELD_BITS(MAX_FIELD_BITS)
	) u_plan (
		.operation   (operation),
		.field_value (field_value),
		.field_width (field_width),
		.cursor      (cursor_q),
		.written     (written_q),
		.plan        (plan),
		.first_byte  (plan_first),
		.nbytes      (plan_nbytes),
		.wbuf        (plan_wbuf),
		.next_cursor (plan_cursor),
		.next_written(plan_written)
	);

	assign item_stall = (state_q != ST_IDLE);
	assign in_xfer    = item_valid && !item_stall;
	assign issue      = (state_q == ST_ACCESS) && (left_q != '0);
	assign res_load   = (state_q == ST_FINISH) && !(res_valid_q && result_stall);

	// The field lies in the low bytes of the window, ending tail_q bits above
	// bit zero. Writes and refused reads leave the window at zero.
	assign read_mask = ~({WB{1'b1}} << width_q);
	assign read_bits = (win_q >> tail_q) & read_mask;
	assign read_x    = DW'(read_bits);
	assign cursor_x  = XW'(cursor_q);
	assign written_x = XW'(written_q);

	// Write port: the clearing pass after reset, else the merge of a fetched
	// byte with its part of the field.
	always_comb begin
		mem_we = 1'b0;
		mem_wa = addr_s1;
		mem_wd = rdata_s1 | wbuf_q[idx_s1];
		if (state_q == ST_CLEAR) begin
			mem_we = 1'b1;
			mem_wa = clr_addr_q;
			mem_wd = '0;
		end else if (v_s1 && is_write_q) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			store_mem[mem_wa] <= mem_wd;
		end
		rdata_s1 <= store_mem[rd_addr_q];
	end

	// Control state and registered outputs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			clr_addr_q    <= '0;
			cursor_q      <= '0;
			written_q     <= '0;
			left_q        <= '0;
			v_s1          <= 1'b0;
			status_q      <= STATUS_DONE;
			is_write_q    <= 1'b0;
			res_valid_q   <= 1'b0;
			res_status_q  <= STATUS_DONE;
			res_data_q    <= '0;
			res_cursor_q  <= '0;
			res_written_q <= '0;
		end else begin
			v_s1 <= issue;
			if (res_valid_q && !result_stall && !res_load) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + AW'(1);
					if (clr_addr_q == AW'(STORE_BYTES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_xfer) begin
						cursor_q   <= plan_cursor;
						written_q  <= plan_written;
						status_q   <= plan.refused ? STATUS_REFUSED : STATUS_DONE;
						is_write_q <= plan.is_write;
						left_q     <= plan.access ? plan_nbytes : '0;
						state_q    <= plan.access ? ST_ACCESS : ST_FINISH;
					end
				end
				ST_ACCESS: begin
					if (issue) begin
						left_q <= left_q - NBW'(1);
					end
					// The last byte is merged or captured in this cycle.
					if ((left_q == '0) && v_s1) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (res_load) begin
						res_valid_q   <= 1'b1;
						res_status_q  <= status_q;
						res_data_q    <= read_x[VALUE_W-1:0];
						res_cursor_q  <= cursor_x[POS_W-1:0];
						res_written_q <= written_x[POS_W-1:0];
						state_q       <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers of the item in progress.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			rd_addr_q <= plan_first;
			tail_q    <= plan.tail_shift;
			width_q   <= field_width;
			win_q     <= '0;
			for (int k = 0; k < NBMAX; k++) begin
				wbuf_q[k] <= plan_wbuf[8 * k +: 8];
			end
		end else begin
			if (issue) begin
				rd_addr_q <= rd_addr_q + AW'(1);
				addr_s1   <= rd_addr_q;
				idx_s1    <= IXW'(left_q - NBW'(1));
			end
			if (v_s1 && !is_write_q) begin
				win_q <= (win_q << 8) | WB'(rdata_s1);
			end
		end
	end

	assign result_valid    = res_valid_q;
	assign read_data       = res_data_q;
	assign status          = res_status_q;
	assign cursor_position = res_cursor_q;
	assign written_total   = res_written_q;

	`BFPU_ASSERT_NEVER(a_cursor_in_store, clk, arst_n, cursor_q > CW'(CAP_BITS), "cursor beyond store end")
	`BFPU_ASSERT_NEVER(a_written_in_store, clk, arst_n, written_q > CW'(CAP_BITS), "written total beyond store end")
	`BFPU_ASSERT_IMPLIES(a_fetch_in_access, clk, arst_n, v_s1, state_q == ST_ACCESS, "fetched byte outside an access")
	`BFPU_ASSERT_NEXT(a_written_grows, clk, arst_n, state_q != ST_CLEAR, written_q >= $past(written_q), "written total decreased")
	`BFPU_ASSERT_NEXT(a_result_loaded, clk, arst_n, res_load, res_valid_q && state_q == ST_IDLE, "result not loaded on finish")

endmodule

`default_nettype wire

/* test/testbench.sv */
// Self-checking testbench for the bit-field packer and unpacker: drives write, read and
// rewind transfers, predicts each result from its own copy of the store and checks it.
// Depends on bfpu_pkg and bit_field_packer_unpacker_unit.
`default_nettype none

module testbench;
	import bfpu_pkg::*;

	// The store holds this many bits; accesses that would pass it are refused.
	localparam int unsigned STORE_BITS   = STORE_BYTES_DEF * BYTE_W;
	// Code 3 is left unused by the block and must be ignored.
	localparam logic [1:0]  OP_UNUSED    = 2'd3;
	localparam int          RANDOM_ITEMS = 1350;
	localparam int          HOLD_CYCLES  = 150;
	// Cycles waited after the last predicted result before the verdict is given.
	localparam int          DRAIN_CYCLES = 20;
	localparam int          CYCLE_LIMIT  = 250000;
	// Writes stop in the random mix here, so the end-of-store test still has room.
	localparam int unsigned WRITE_CEILING = 1700;

	typedef struct packed {
		logic [VALUE_W-1:0] read_data;
		logic               status;
		logic [POS_W-1:0]   cursor_position;
		logic [POS_W-1:0]   written_total;
	} field_result_t;

	logic               clk;
	logic               arst_n       = 1'b0;
	logic               item_valid   = 1'b0;
	logic               item_stall;
	logic [1:0]         operation    = OP_REWIND;
	logic [VALUE_W-1:0] field_value  = '0;
	logic [WIDTH_W-1:0] field_width  = '0;
	logic               result_valid;
	logic               result_stall = 1'b0;
	logic [VALUE_W-1:0] read_data;
	logic               status;
	logic [POS_W-1:0]   cursor_position;
	logic [POS_W-1:0]   written_total;

	// Predicted state of the block: the byte store, the bit cursor and the written total.
	logic [BYTE_W-1:0] store_image [STORE_BYTES_DEF] = '{default: '0};
	int unsigned       bit_pos    = 0;
	int unsigned       bits_total = 0;

	// Results predicted for accepted transfers, oldest first.
	field_result_t pending_results [$];

	int  mismatch_count  = 0;
	int  cycle_count     = 0;
	bit  sender_idling   = 1'b0;
	bit  receiver_idling = 1'b0;
	bit  hold_off_req    = 1'b0;
	int  hold_left       = 0;
	int  burst_left      = 0;

	bit_field_packer_unpacker_unit i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.item_valid      (item_valid),
		.item_stall      (item_stall),
		.operation       (operation),
		.field_value     (field_value),
		.field_width     (field_width),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.read_data       (read_data),
		.status          (status),
		.cursor_position (cursor_position),
		.written_total   (written_total)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Applies one operation to the predicted state and returns the result it must give.
	// Bit position p lives in bit (7 - p mod 8) of byte p / 8, so fields run MSB first.
	function automatic field_result_t apply_field_op(input logic [1:0] op,
			input logic [VALUE_W-1:0] value, input logic [WIDTH_W-1:0] width);
		field_result_t res;
		int unsigned   nbits;
		int unsigned   pos;
		res   = '0;
		nbits = 32'(width);
		if (op == OP_WRITE || op == OP_READ) begin
			if (nbits > MAX_FIELD_BITS_DEF) begin
				res.status = STATUS_REFUSED;
			end else if (op == OP_WRITE) begin
				// Both the cursor and the running total have to stay within the store.
				if (bit_pos + nbits > STORE_BITS || bits_total + nbits > STORE_BITS) begin
					res.status = STATUS_REFUSED;
				end else begin
					for (int i = 0; i < nbits; i++) begin
						pos = bit_pos + i;
						store_image[pos / BYTE_W][BYTE_W - 1 - pos % BYTE_W] =
							store_image[pos / BYTE_W][BYTE_W - 1 - pos % BYTE_W] |
							value[nbits - 1 - i];
					end
					bit_pos    += nbits;
					bits_total += nbits;
				end
			end else begin
				if (bit_pos + nbits > STORE_BITS) begin
					res.status = STATUS_REFUSED;
				end else begin
					for (int i = 0; i < nbits; i++) begin
						pos = bit_pos + i;
						res.read_data = {res.read_data[VALUE_W-2:0],
							store_image[pos / BYTE_W][BYTE_W - 1 - pos % BYTE_W]};
					end
					bit_pos += nbits;
				end
			end
		end else if (op == OP_REWIND) begin
			// The written total survives a rewind.
			bit_pos = 0;
		end
		res.cursor_position = bit_pos[POS_W-1:0];
		res.written_total   = bits_total[POS_W-1:0];
		return res;
	endfunction

	// Offers one item, with an optional gap before it, and returns at the rising edge at
	// which the transfer takes place. It must be called at a rising edge. The stall is
	// sampled at the falling edge, where it has long settled, and the prediction is
	// queued there, well before the block can answer.
	task automatic transfer_item(input logic [1:0] op, input logic [VALUE_W-1:0] value,
			input logic [WIDTH_W-1:0] width);
		int gap;
		gap = 0;
		if (sender_idling && $urandom_range(0, 3) == 0)
			gap = $urandom_range(1, 11);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid  <= 1'b1;
		operation   <= op;
		field_value <= value;
		field_width <= width;
		do @(negedge clk); while (item_stall);
		pending_results.push_back(apply_field_op(op, value, width));
		@(posedge clk);
	endtask

	// Mostly narrow fields so that the limited store lasts, with wide ones mixed in.
	function automatic logic [WIDTH_W-1:0] pick_width();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 70)
			return WIDTH_W'($urandom_range(1, 8));
		else if (roll < 95)
			return WIDTH_W'($urandom_range(1, MAX_FIELD_BITS_DEF));
		else if (roll < 98)
			return WIDTH_W'(MAX_FIELD_BITS_DEF);
		return '0;
	endfunction

	task automatic check_field(input string name, input logic [VALUE_W-1:0] want,
			input logic [VALUE_W-1:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	// A result transfer happens at the rising edge after a falling edge that sees valid
	// high and stall low; both are stable at the falling edge, so it is checked there.
	always @(negedge clk) begin
		field_result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %0h %0h %0h %0h",
					$time, read_data, status, cursor_position, written_total);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("read_data", want.read_data, read_data);
				check_field("status", VALUE_W'(want.status), VALUE_W'(status));
				check_field("cursor_position", VALUE_W'(want.cursor_position),
					VALUE_W'(cursor_position));
				check_field("written_total", VALUE_W'(want.written_total),
					VALUE_W'(written_total));
			end
		end
	end

	// The receiver: a requested hold-off is counted down here, otherwise random bursts of
	// stall are inserted while idling is enabled.
	always @(posedge clk) begin
		if (hold_off_req) begin
			hold_left    = HOLD_CYCLES;
			hold_off_req = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else if (burst_left > 0) begin
			burst_left--;
			result_stall <= 1'b1;
		end else if (receiver_idling && $urandom_range(0, 5) == 0) begin
			burst_left = $urandom_range(0, 10);
			result_stall <= 1'b1;
		end else begin
			result_stall <= 1'b0;
		end
	end

	// A run that hangs is cut off here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("bit_field_packer_unpacker_unit verification failed");
			$finish;
		end
	end

	// Field extremes, every operation, zero width, over-wide fields, the unused code and
	// the fact that a write only ever sets bits.
	task automatic directed_edge_test();
		sender_idling   = 1'b1;
		receiver_idling = 1'b1;
		transfer_item(OP_READ, 32'hFFFF_FFFF, 6'd32);
		transfer_item(OP_REWIND, 32'hFFFF_FFFF, 6'd63);
		transfer_item(OP_WRITE, 32'h0000_0001, 6'd1);
		transfer_item(OP_WRITE, 32'hFFFF_FFFF, 6'd32);
		transfer_item(OP_WRITE, 32'h0000_0000, 6'd32);
		// Bits above the field width must be ignored.
		transfer_item(OP_WRITE, 32'hFFFF_FFD5, 6'd7);
		transfer_item(OP_WRITE, 32'hFFFF_FFFE, 6'd1);
		transfer_item(OP_WRITE, 32'hA5A5_5A5A, 6'd0);
		transfer_item(OP_READ, 32'h5A5A_A5A5, 6'd0);
		transfer_item(OP_WRITE, 32'hFFFF_FFFF, 6'd33);
		transfer_item(OP_WRITE, 32'hFFFF_FFFF, 6'd63);
		transfer_item(OP_READ, 32'h0000_0000, 6'd33);
		transfer_item(OP_READ, 32'h0000_0000, 6'd63);
		transfer_item(OP_UNUSED, 32'hFFFF_FFFF, 6'd63);
		transfer_item(OP_UNUSED, 32'h0000_0000, 6'd8);
		transfer_item(OP_REWIND, 32'h0000_0000, 6'd0);
		transfer_item(OP_READ, 32'h0000_0000, 6'd1);
		transfer_item(OP_READ, 32'h0000_0000, 6'd32);
		transfer_item(OP_READ, 32'h0000_0000, 6'd32);
		transfer_item(OP_READ, 32'h0000_0000, 6'd7);
		transfer_item(OP_READ, 32'h0000_0000, 6'd1);
		// Writing over bits already set must OR, never clear.
		transfer_item(OP_REWIND, 32'h0000_0000, 6'd0);
		transfer_item(OP_WRITE, 32'h0000_000F, 6'd8);
		transfer_item(OP_REWIND, 32'h0000_0000, 6'd0);
		transfer_item(OP_READ, 32'h0000_0000, 6'd16);
	endtask

	// The receiver holds off for a long stretch while the sender keeps offering items,
	// so the output register fills and the block stalls its input.
	task automatic pressure_test();
		sender_idling   = 1'b0;
		receiver_idling = 1'b0;
		hold_off_req    = 1'b1;
		for (int n = 0; n < 24; n++)
			transfer_item($urandom_range(0, 1) ? OP_READ : OP_WRITE, $urandom, pick_width());
	endtask

	// Random mix of all operations. Idling comes and goes in stretches of 150 items, and
	// writes cease once the total nears the ceiling so the store is not filled too soon.
	task automatic random_mix_test();
		int unsigned        roll;
		logic [1:0]         op;
		logic [WIDTH_W-1:0] width;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			sender_idling   = (n / 150) % 3 != 2;
			receiver_idling = (n / 150) % 3 != 1;
			roll  = $urandom_range(0, 99);
			width = pick_width();
			if (roll < 28)
				op = bits_total < WRITE_CEILING ? OP_WRITE : OP_READ;
			else if (roll < 80)
				op = OP_READ;
			else if (roll < 91)
				op = OP_REWIND;
			else if (roll < 95)
				op = OP_UNUSED;
			else begin
				op    = $urandom_range(0, 1) ? OP_READ : OP_WRITE;
				width = WIDTH_W'($urandom_range(MAX_FIELD_BITS_DEF + 1, 63));
			end
			if (op == OP_REWIND || op == OP_UNUSED)
				width = WIDTH_W'($urandom_range(0, 63));
			transfer_item(op, $urandom, width);
		end
	endtask

	// Walks the cursor to the very end of the store and then fills the written total,
	// checking that accesses running past either limit are refused. No idling here.
	task automatic store_end_test();
		sender_idling   = 1'b0;
		receiver_idling = 1'b0;
		transfer_item(OP_REWIND, $urandom, WIDTH_W'($urandom_range(0, 63)));
		while (bit_pos + MAX_FIELD_BITS_DEF <= STORE_BITS)
			transfer_item(OP_READ, $urandom,
				WIDTH_W'($urandom_range(1, MAX_FIELD_BITS_DEF)));
		if (bit_pos < STORE_BITS)
			transfer_item(OP_READ, $urandom, WIDTH_W'(STORE_BITS - bit_pos));
		// The cursor now sits at the end: any further access of one bit or more is refused.
		transfer_item(OP_READ, $urandom, 6'd1);
		transfer_item(OP_WRITE, $urandom, 6'd32);
		transfer_item(OP_READ, $urandom, 6'd0);
		transfer_item(OP_REWIND, $urandom, WIDTH_W'($urandom_range(0, 63)));
		while (bits_total + MAX_FIELD_BITS_DEF <= STORE_BITS)
			transfer_item(OP_WRITE, $urandom,
				WIDTH_W'($urandom_range(1, MAX_FIELD_BITS_DEF)));
		if (bits_total < STORE_BITS)
			transfer_item(OP_WRITE, $urandom, WIDTH_W'(STORE_BITS - bits_total));
		// The written total is full, so the next write is refused even with the cursor free.
		transfer_item(OP_REWIND, $urandom, 6'd0);
		transfer_item(OP_WRITE, $urandom, 6'd1);
		transfer_item(OP_WRITE, $urandom, 6'd0);
		transfer_item(OP_READ, $urandom, 6'd32);
		transfer_item(OP_READ, $urandom, 6'd32);
	endtask

	// Reset once, run the tests in turn, let the block drain and give the verdict. The
	// block clears its store for a while after reset; the first transfer simply waits.
	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed_edge_test();
		pressure_test();
		random_mix_test();
		store_end_test();
		item_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("bit_field_packer_unpacker_unit verification clean");
		else
			$display("bit_field_packer_unpacker_unit verification failed");
		$finish;
	end

endmodule

`default_nettype wire

/* sim.f */
+incdir+src
src/bfpu_pkg.sv
src/bfpu_plan.sv
src/bit_field_packer_unpacker_unit.sv
test/testbench.sv
